>>> src/bpcm_pkg.sv
// ----------------------------------------------------------------------------
// bpcm_pkg
// Shared widths, constants and controller/datapath interface types for the
// battery pack cell monitor.
// ----------------------------------------------------------------------------
package bpcm_pkg;

  // field widths
  localparam int MV_W      = 16;
  localparam int SUM_W     = 20;
  localparam int PCT_W     = 7;
  localparam int CCOUNT_W  = 5;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_W     = MV_W + PCT_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_MV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_MV    = 3'd4;

  // configuration reset values
  localparam logic [CCOUNT_W-1:0] CELL_COUNT_RST = 5'd12;
  localparam logic [MV_W-1:0]     EMPTY_MV_RST   = 16'd3000;
  localparam logic [MV_W-1:0]     FULL_MV_RST    = 16'd4200;
  localparam logic [MV_W-1:0]     WARN_MV_RST    = 16'd50;
  localparam logic [MV_W-1:0]     CRIT_MV_RST    = 16'd150;

  // accumulator and result constants
  localparam logic [MV_W-1:0]  LOW_RESET    = 16'hFFFF;
  localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
  localparam logic [PCT_W-1:0] SOH_WARN     = 7'd85;
  localparam logic [PCT_W-1:0] SOH_CRIT     = 7'd60;
  localparam logic [PCT_W-1:0] STATUS_OK    = 7'd0;
  localparam logic [2:0]       DIV_TOP_BIT  = 3'd6;

  // result status codes
  localparam logic STAT_VALID = 1'b0;
  localparam logic STAT_FAULT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic acc_upd;    // fold the accepted cell into the accumulators
    logic acc_clr;    // restart the pack accumulators
    logic snap;       // capture the closing pack into the result registers
    logic mark_fault; // result is an aborted reading
    logic prep;       // delta, charge class and division operands
    logic div_step;   // one quotient bit
    logic load_out;   // move the result into the output register
  } bpcm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_cell;  // the cell on the input closes the pack
    logic div_last;   // current division step is the final one
    logic out_free;   // output register can take a result this cycle
  } bpcm_stat_t;

endpackage

>>> src/battery_pack_cell_monitor.sv
// ----------------------------------------------------------------------------
// battery_pack_cell_monitor
// Accumulates per-cell voltages into a pack summary with minimum, imbalance,
// state of charge and state of health; a front-end fault aborts the pack.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  in       | in_valid_i / in_stall_o   | cell_mv_i, afe_fault_i
//  out      | out_valid_o / out_stall_i | status_o, pack_mv_o, lowest_mv_o,
//           |                           | cell_delta_mv_o, charge_percent_o,
//           |                           | health_percent_o
//  cfg      | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A cell that does not close the pack is folded into the accumulators as it is taken.
// The closing cell's summary reaches the output register through capture, operand
// setup, 7 steps of the bit-serial charge divider, then the load, which waits until
// the output register is free; a fault transfer goes from capture straight to the load.
// Cells keep being taken while a summary waits in the output register.
// Reset loads the register defaults and empties the pack; no clearing pass.
// ----------------------------------------------------------------------------
module battery_pack_cell_monitor #(
  parameter int MAX_CELLS = 16,
  parameter int CELL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpcm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bpcm_pkg::MV_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bpcm_pkg::MV_W-1:0]      cell_mv_i,
  input  logic                           afe_fault_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           status_o,
  output logic [bpcm_pkg::SUM_W-1:0]     pack_mv_o,
  output logic [bpcm_pkg::MV_W-1:0]      lowest_mv_o,
  output logic [bpcm_pkg::MV_W-1:0]      cell_delta_mv_o,
  output logic [bpcm_pkg::PCT_W-1:0]     charge_percent_o,
  output logic [bpcm_pkg::PCT_W-1:0]     health_percent_o
);
  import bpcm_pkg::*;

  bpcm_cmd_t  cmd;
  bpcm_stat_t stat;
  logic       in_ready;

  assign in_stall_o = !in_ready;

  // sequencer
  bpcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .afe_fault_i (afe_fault_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  // accumulators, divider and output register
  bpcm_dp #(
    .MAX_CELLS (MAX_CELLS),
    .CELL_BITS (CELL_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .cell_mv_i        (cell_mv_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .pack_mv_o        (pack_mv_o),
    .lowest_mv_o      (lowest_mv_o),
    .cell_delta_mv_o  (cell_delta_mv_o),
    .charge_percent_o (charge_percent_o),
    .health_percent_o (health_percent_o)
  );

endmodule

>>> src/bpcm_ctrl.sv
// ----------------------------------------------------------------------------
// bpcm_ctrl
// Sequencer for the cell monitor: accepts cells, runs the charge division
// after the closing cell and hands the result to the output register.
// ----------------------------------------------------------------------------
module bpcm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 afe_fault_i,
  input  bpcm_pkg::bpcm_stat_t stat_i,
  output logic                 in_ready_o,
  output bpcm_pkg::bpcm_cmd_t  cmd_o
);
  import bpcm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (afe_fault_i) begin
            cmd_o.acc_clr    = 1'b1;
            cmd_o.mark_fault = 1'b1;
            state_d          = ST_HOLD;
          end else if (stat_i.last_cell) begin
            cmd_o.acc_clr = 1'b1;
            cmd_o.snap    = 1'b1;
            state_d       = ST_PREP;
          end else begin
            cmd_o.acc_upd = 1'b1;
          end
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/bpcm_dp.sv
// ----------------------------------------------------------------------------
// bpcm_dp
// Datapath: configuration registers, pack accumulators, result capture,
// bit-serial charge divider and the output register.
// ----------------------------------------------------------------------------
module bpcm_dp #(
  parameter int MAX_CELLS = 16,
  parameter int CELL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpcm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bpcm_pkg::MV_W-1:0]      cfg_data_i,
  input  logic [bpcm_pkg::MV_W-1:0]      cell_mv_i,
  input  bpcm_pkg::bpcm_cmd_t            cmd_i,
  output bpcm_pkg::bpcm_stat_t           stat_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic                           status_o,
  output logic [bpcm_pkg::SUM_W-1:0]     pack_mv_o,
  output logic [bpcm_pkg::MV_W-1:0]      lowest_mv_o,
  output logic [bpcm_pkg::MV_W-1:0]      cell_delta_mv_o,
  output logic [bpcm_pkg::PCT_W-1:0]     charge_percent_o,
  output logic [bpcm_pkg::PCT_W-1:0]     health_percent_o
);
  import bpcm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CELLS + 1);
  localparam int CMP_W  = ((CNT_W > CCOUNT_W) ? CNT_W : CCOUNT_W) + 1;
  localparam logic [MV_W-1:0]  CellMask = MV_W'((32'd1 << CELL_BITS) - 32'd1);
  localparam logic [CMP_W-1:0] MaxCnt   = CMP_W'(MAX_CELLS);

  // configuration registers
  logic [CCOUNT_W-1:0] cell_count_q;
  logic [MV_W-1:0]     empty_mv_q, full_mv_q, warn_mv_q, crit_mv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= CELL_COUNT_RST;
      empty_mv_q   <= EMPTY_MV_RST;
      full_mv_q    <= FULL_MV_RST;
      warn_mv_q    <= WARN_MV_RST;
      crit_mv_q    <= CRIT_MV_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CELL_COUNT: cell_count_q <= cfg_data_i[CCOUNT_W-1:0];
        REG_EMPTY_MV:   empty_mv_q   <= cfg_data_i;
        REG_FULL_MV:    full_mv_q    <= cfg_data_i;
        REG_WARN_MV:    warn_mv_q    <= cfg_data_i;
        REG_CRIT_MV:    crit_mv_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pack accumulators
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [MV_W-1:0]  low_q, low_d, high_q, high_d;
  logic [CNT_W-1:0] cnt_q;
  logic [MV_W-1:0]  mv;
  logic [CMP_W-1:0] eff_cnt, cnt_inc;

  assign mv     = cell_mv_i & CellMask;
  assign sum_d  = sum_q + SUM_W'(mv);
  assign low_d  = (mv < low_q) ? mv : low_q;
  assign high_d = (mv > high_q) ? mv : high_q;

  // effective cell count, clamped to one..MAX_CELLS
  always_comb begin
    eff_cnt = CMP_W'(cell_count_q);
    if (eff_cnt == '0) begin
      eff_cnt = CMP_W'(1);
    end else if (eff_cnt > MaxCnt) begin
      eff_cnt = MaxCnt;
    end
  end

  assign cnt_inc          = CMP_W'(cnt_q) + CMP_W'(1);
  assign stat_o.last_cell = (cnt_inc >= eff_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      low_q  <= LOW_RESET;
      high_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.acc_clr) begin
      sum_q  <= '0;
      low_q  <= LOW_RESET;
      high_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.acc_upd) begin
      sum_q  <= sum_d;
      low_q  <= low_d;
      high_q <= high_d;
      cnt_q  <= cnt_inc[CNT_W-1:0];
    end
  end

  // result capture of the closing pack
  logic             res_fault_q;
  logic [SUM_W-1:0] res_sum_q;
  logic [MV_W-1:0]  res_min_q, res_max_q, res_delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_fault_q <= STAT_VALID;
    end else if (cmd_i.mark_fault) begin
      res_fault_q <= STAT_FAULT;
    end else if (cmd_i.snap) begin
      res_fault_q <= STAT_VALID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      res_sum_q <= sum_d;
      res_min_q <= low_d;
      res_max_q <= high_d;
    end
    if (cmd_i.prep) begin
      res_delta_q <= res_max_q - res_min_q;
    end
  end

  // charge class and division operands
  logic             soc_full_q, soc_empty_q;
  logic [MV_W-1:0]  den_q;
  logic [NUM_W-1:0] rem_q, num, den_sh;
  logic [PCT_W-1:0] quo_q;
  logic [2:0]       div_bit_q;
  logic             rem_ge;

  assign num    = NUM_W'(res_min_q - empty_mv_q) * NUM_W'(PCT_FULL);
  assign den_sh = NUM_W'(den_q) << div_bit_q;
  assign rem_ge = (rem_q >= den_sh);

  assign stat_o.div_last = (div_bit_q == '0);

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      soc_full_q  <= (res_min_q >= full_mv_q);
      soc_empty_q <= (res_min_q <= empty_mv_q);
      den_q       <= full_mv_q - empty_mv_q;
      rem_q       <= num;
      quo_q       <= '0;
      div_bit_q   <= DIV_TOP_BIT;
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q            <= rem_q - den_sh;
        quo_q[div_bit_q] <= 1'b1;
      end
      div_bit_q <= div_bit_q - 3'd1;
    end
  end

  // output register
  logic             out_valid_q;
  logic [PCT_W-1:0] soc, soh;

  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    priority if (soc_full_q) begin
      soc = PCT_FULL;
    end else if (soc_empty_q) begin
      soc = STATUS_OK;
    end else begin
      soc = quo_q;
    end
    priority if (res_delta_q > crit_mv_q) begin
      soh = SOH_CRIT;
    end else if (res_delta_q > warn_mv_q) begin
      soh = SOH_WARN;
    end else begin
      soh = PCT_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o <= res_fault_q;
      if (res_fault_q == STAT_FAULT) begin
        pack_mv_o        <= '0;
        lowest_mv_o      <= '0;
        cell_delta_mv_o  <= '0;
        charge_percent_o <= '0;
        health_percent_o <= '0;
      end else begin
        pack_mv_o        <= res_sum_q;
        lowest_mv_o      <= res_min_q;
        cell_delta_mv_o  <= res_delta_q;
        charge_percent_o <= soc;
        health_percent_o <= soh;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> tb/tb_battery_pack_cell_monitor.sv
// ----------------------------------------------------------------------------
// tb_battery_pack_cell_monitor
// Self-checking bench for the pack monitor. Cell readings are sent over the
// valid/stall input channel and mirrored in a local pack predictor. Each pack
// summary or fault report leaving the block is compared field by field with
// the oldest predicted report. Directed cases come first, then random packs
// under changing limits, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_battery_pack_cell_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  import bpcm_pkg::*;

  localparam int MAX_CELLS       = 16;
  localparam int CELL_BITS       = 16;
  localparam logic [MV_W-1:0] CELL_MASK = MV_W'((1 << CELL_BITS) - 1);
  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int NUM_REG_SLOTS   = 1 << CFG_IDX_W;

  typedef struct packed {
    logic             status;
    logic [SUM_W-1:0] pack_mv;
    logic [MV_W-1:0]  min_mv;
    logic [MV_W-1:0]  delta_mv;
    logic [PCT_W-1:0] charge;
    logic [PCT_W-1:0] health;
  } pack_report_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [MV_W-1:0]      cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [MV_W-1:0]      cell_mv_i;
  logic                 afe_fault_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 status_o;
  logic [SUM_W-1:0]     pack_mv_o;
  logic [MV_W-1:0]      lowest_mv_o;
  logic [MV_W-1:0]      cell_delta_mv_o;
  logic [PCT_W-1:0]     charge_percent_o;
  logic [PCT_W-1:0]     health_percent_o;

  // predicted configuration
  logic [CCOUNT_W-1:0] cfg_cells;
  logic [MV_W-1:0]     cfg_empty;
  logic [MV_W-1:0]     cfg_full;
  logic [MV_W-1:0]     cfg_warn;
  logic [MV_W-1:0]     cfg_crit;

  // predicted pack accumulators
  logic [SUM_W-1:0] pack_sum;
  logic [MV_W-1:0]  pack_low;
  logic [MV_W-1:0]  pack_high;
  int unsigned      pack_cells;

  pack_report_t pending_reports[$];
  int           error_count = 0;
  bit           gaps_on     = 1'b1;
  bit           stall_on    = 1'b1;

  battery_pack_cell_monitor #(
    .MAX_CELLS (MAX_CELLS),
    .CELL_BITS (CELL_BITS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cell_mv_i        (cell_mv_i),
    .afe_fault_i      (afe_fault_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .pack_mv_o        (pack_mv_o),
    .lowest_mv_o      (lowest_mv_o),
    .cell_delta_mv_o  (cell_delta_mv_o),
    .charge_percent_o (charge_percent_o),
    .health_percent_o (health_percent_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // pack predictor
  // ---------------------------------------------------------------------------

  task automatic clear_pack();
    pack_sum   = '0;
    pack_low   = LOW_RESET;
    pack_high  = '0;
    pack_cells = 0;
  endtask

  task automatic predict_pack(input logic [MV_W-1:0] mv, input logic fault);
    pack_report_t rep;
    logic [MV_W-1:0] masked_mv;
    int unsigned closing;
    int unsigned scaled;
    rep       = '0;
    masked_mv = mv & CELL_MASK;
    if (fault) begin
      // aborted reading: every other field stays zero
      rep.status = STAT_FAULT;
      pending_reports.push_back(rep);
      clear_pack();
    end else begin
      pack_sum = pack_sum + SUM_W'(masked_mv);
      if (masked_mv < pack_low) pack_low = masked_mv;
      if (masked_mv > pack_high) pack_high = masked_mv;
      pack_cells++;
      // out of range cell counts are clamped
      if (cfg_cells == 0) closing = 1;
      else if (cfg_cells > MAX_CELLS) closing = MAX_CELLS;
      else closing = cfg_cells;
      if (pack_cells >= closing) begin
        rep.status   = STAT_VALID;
        rep.pack_mv  = pack_sum;
        rep.min_mv   = pack_low;
        rep.delta_mv = pack_high - pack_low;
        // health tier from imbalance
        if (rep.delta_mv > cfg_crit) rep.health = SOH_CRIT;
        else if (rep.delta_mv > cfg_warn) rep.health = SOH_WARN;
        else rep.health = PCT_FULL;
        // charge from the weakest cell, full limit checked first
        if (pack_low >= cfg_full) begin
          rep.charge = PCT_FULL;
        end else if (pack_low <= cfg_empty) begin
          rep.charge = '0;
        end else begin
          scaled     = 32'(pack_low - cfg_empty) * 32'd100;
          rep.charge = PCT_W'(scaled / 32'(cfg_full - cfg_empty));
        end
        pending_reports.push_back(rep);
        clear_pack();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MV_W-1:0] clip_mv(input int v);
    if (v < 0) return '0;
    if (v > int'({MV_W{1'b1}})) return '1;
    return MV_W'(v);
  endfunction

  // one input transfer; valid stays high afterwards for a back-to-back item
  task automatic send_cell(input logic [MV_W-1:0] mv, input logic fault);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cell_mv_i   <= mv;
    afe_fault_i <= fault;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pack(mv, fault);
  endtask

  // hold the input until every report is out and the block has gone quiet
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write every register slot, the unused indexes with random data
  task automatic apply_setting(input logic [MV_W-1:0] count_word,
                               input logic [MV_W-1:0] empty_mv,
                               input logic [MV_W-1:0] full_mv,
                               input logic [MV_W-1:0] warn_mv,
                               input logic [MV_W-1:0] crit_mv);
    logic [MV_W-1:0] values[NUM_REG_SLOTS];
    logic [CFG_IDX_W-1:0] idx;
    foreach (values[i]) values[i] = MV_W'($urandom);
    values[REG_CELL_COUNT] = count_word;
    values[REG_EMPTY_MV]   = empty_mv;
    values[REG_FULL_MV]    = full_mv;
    values[REG_WARN_MV]    = warn_mv;
    values[REG_CRIT_MV]    = crit_mv;
    for (int i = 0; i < NUM_REG_SLOTS; i++) begin
      idx = CFG_IDX_W'(i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= values[i];
      @(posedge clk_i);
      case (idx)
        REG_CELL_COUNT: cfg_cells = values[i][CCOUNT_W-1:0];
        REG_EMPTY_MV:   cfg_empty = values[i];
        REG_FULL_MV:    cfg_full  = values[i];
        REG_WARN_MV:    cfg_warn  = values[i];
        REG_CRIT_MV:    cfg_crit  = values[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // twelve-cell pack under reset limits, imbalance in the warning tier
  task automatic test_default_pack();
    for (int i = 0; i < 12; i++) send_cell(MV_W'(3600 + i * 5), 1'b0);
    drain_reports();
  endtask

  // fault mid-pack, then a fault with no pack open
  task automatic test_fault_abort();
    send_cell(16'd3700, 1'b0);
    send_cell(16'd3800, 1'b0);
    send_cell(16'hFFFF, 1'b1);
    send_cell(16'd0, 1'b1);
    drain_reports();
  endtask

  // zero cell count acts as one; lowest, highest and a mid-range cell
  task automatic test_field_extremes();
    apply_setting(16'd0, EMPTY_MV_RST, FULL_MV_RST, WARN_MV_RST, CRIT_MV_RST);
    send_cell(16'd0, 1'b0);
    send_cell(16'hFFFF, 1'b0);
    send_cell(16'd3599, 1'b0);
    drain_reports();
  endtask

  // shrink the cell count while a pack is open
  task automatic test_count_change_mid_pack();
    apply_setting(16'd4, EMPTY_MV_RST, FULL_MV_RST, WARN_MV_RST, CRIT_MV_RST);
    send_cell(16'd3900, 1'b0);
    send_cell(16'd4000, 1'b0);
    drain_reports();
    apply_setting(16'd2, EMPTY_MV_RST, FULL_MV_RST, WARN_MV_RST, CRIT_MV_RST);
    send_cell(16'd3950, 1'b0);
    drain_reports();
  endtask

  // full limit below empty limit: charge is only ever 100 or 0
  task automatic test_inverted_limits();
    apply_setting(16'd1, 16'd2000, 16'd1000, WARN_MV_RST, CRIT_MV_RST);
    send_cell(16'd1500, 1'b0);
    send_cell(16'd500, 1'b0);
    drain_reports();
  endtask

  // delta exactly at the warning limit, then just above the critical one
  task automatic test_health_tiers();
    apply_setting(16'd2, EMPTY_MV_RST, FULL_MV_RST, WARN_MV_RST, CRIT_MV_RST);
    send_cell(16'd4000, 1'b0);
    send_cell(16'd4050, 1'b0);
    send_cell(16'd4000, 1'b0);
    send_cell(16'd3849, 1'b0);
    drain_reports();
  endtask

  // random packs under a new setting per phase
  task automatic test_random_traffic();
    logic [MV_W-1:0] lo_lim, hi_lim, warn_mv, crit_mv, count_word, base, spread;
    int unsigned roll;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // charge limits
      roll = $urandom_range(0, 3);
      case (roll)
        0: begin
          lo_lim = MV_W'($urandom_range(2500, 3300));
          hi_lim = MV_W'($urandom_range(3800, 4300));
        end
        1: begin
          lo_lim = MV_W'($urandom);
          hi_lim = MV_W'($urandom);
        end
        2: begin
          lo_lim = '0;
          hi_lim = '1;
        end
        default: begin
          lo_lim = MV_W'($urandom);
          hi_lim = lo_lim;
        end
      endcase
      // imbalance limits, extremes in two phases
      if (phase == 2) begin
        warn_mv = '0;
        crit_mv = '1;
      end else if (phase == 5) begin
        warn_mv = '1;
        crit_mv = '0;
      end else begin
        warn_mv = MV_W'($urandom_range(0, 200));
        crit_mv = MV_W'($urandom_range(0, 400));
      end
      // cell count, upper data bits random where they are ignored
      count_word = MV_W'($urandom);
      case (phase)
        0: count_word = 16'd1;
        1: count_word = MV_W'(MAX_CELLS);
        2: count_word = 16'd0;
        3: count_word[CCOUNT_W-1:0] = '1;
        default: ;
      endcase
      apply_setting(count_word, lo_lim, hi_lim, warn_mv, crit_mv);
      gaps_on  = (phase != 1 && phase != 5);
      stall_on = (phase != 1 && phase != 6);
      base     = lo_lim;
      spread   = '0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // pressure: sender waits for every outstanding report
        if (n == ITEMS_PER_PHASE / 2 && phase % 2 == 0) drain_reports();
        // new pack: pick a level and an imbalance
        if (pack_cells == 0) begin
          if ($urandom_range(0, 9) < 8)
            base = clip_mv(int'($urandom_range(lo_lim, hi_lim)) +
                           int'($urandom_range(0, 600)) - 300);
          else
            base = MV_W'($urandom);
          case ($urandom_range(0, 3))
            0: spread = '0;
            1: spread = clip_mv(int'(warn_mv) + 5);
            2: spread = clip_mv(int'(crit_mv) + 20);
            default: spread = '1;
          endcase
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) send_cell(MV_W'($urandom), 1'b1);
        else if (roll < 12) send_cell(MV_W'($urandom), 1'b0);
        else send_cell(clip_mv(int'(base) + int'($urandom_range(0, spread))), 1'b0);
      end
      drain_reports();
    end
  endtask

  // ---------------------------------------------------------------------------
  // output stall pattern: mostly short runs, a few long stalls
  // ---------------------------------------------------------------------------
  initial begin : out_stall_gen
    int unsigned roll;
    int unsigned run;
    logic level;
    out_stall_i = 1'b0;
    forever begin
      roll = $urandom_range(0, 99);
      if (!stall_on || roll < 55) begin
        level = 1'b0;
        run   = $urandom_range(1, 6);
      end else if (roll < 93) begin
        level = 1'b1;
        run   = $urandom_range(1, 3);
      end else begin
        level = 1'b1;
        run   = $urandom_range(15, 60);
      end
      @(posedge clk_i);
      out_stall_i <= level;
      repeat (run - 1) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // report checker
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string field,
                                      input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : report_check
    pack_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report with none outstanding, status %0d pack_mv %0d",
                 $time, status_o, pack_mv_o);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", want.status, status_o);
        check_field("pack_mv", want.pack_mv, pack_mv_o);
        check_field("lowest_mv", want.min_mv, lowest_mv_o);
        check_field("cell_delta_mv", want.delta_mv, cell_delta_mv_o);
        check_field("charge_percent", want.charge, charge_percent_o);
        check_field("health_percent", want.health, health_percent_o);
      end
    end
  end

  // watchdog: too long without any transfer or register write
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d reports outstanding", $time, pending_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    cell_mv_i   = '0;
    afe_fault_i = 1'b0;
    cfg_cells   = CELL_COUNT_RST;
    cfg_empty   = EMPTY_MV_RST;
    cfg_full    = FULL_MV_RST;
    cfg_warn    = WARN_MV_RST;
    cfg_crit    = CRIT_MV_RST;
    clear_pack();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_pack();
    test_fault_abort();
    test_field_extremes();
    test_count_change_mid_pack();
    test_inverted_limits();
    test_health_tiers();
    test_random_traffic();

    // final drain with the output always ready
    stall_on = 1'b0;
    drain_reports();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
